[hw/rtl/mrfd_pkg.sv]
package mrfd_pkg;

    localparam int MOTOR_COUNT_DEF = 8;

    localparam logic [10:0] REPLY_BASE_ID_RESET  = 11'h581;
    localparam logic [10:0] TEMP_MODULE_ID_RESET = 11'h589;

    localparam logic [0:0] CFG_REPLY_BASE_ID  = 1'b0;
    localparam logic [0:0] CFG_TEMP_MODULE_ID = 1'b1;

    localparam logic [3:0] FRAME_LEN_VALID = 4'd8;

    localparam logic [7:0] PREAMBLE_STATUS = 8'h2B;
    localparam logic [7:0] PREAMBLE_INFO   = 8'h23;

    localparam logic [7:0] STATUS_CODE_FAULT   = 8'h80;
    localparam logic [7:0] STATUS_CODE_STOPPED = 8'h0E;
    localparam logic [7:0] STATUS_CODE_STARTED = 8'h07;
    localparam logic [7:0] STATUS_CODE_ENABLED = 8'h0F;

    localparam logic [7:0] INFO_FRESH_ONLY = 8'h00;
    localparam logic [7:0] INFO_FORWARD    = 8'h03;
    localparam logic [7:0] INFO_REVERSE    = 8'h05;

    typedef enum logic [2:0] {
        KIND_BAD_LENGTH = 3'd0,
        KIND_TEMPERATURE = 3'd1,
        KIND_STATUS = 3'd2,
        KIND_TELEMETRY = 3'd3,
        KIND_NO_CHANGE = 3'd4,
        KIND_UNKNOWN_ID = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        MS_FAULT = 2'd0,
        MS_STOPPED = 2'd1,
        MS_ENABLED = 2'd2,
        MS_STARTED = 2'd3
    } motor_state_t;

    typedef struct packed {
        motor_state_t state;
        logic [15:0] speed;
        logic [15:0] current;
        logic [31:0] frames;
    } motor_entry_t;

    localparam motor_entry_t MOTOR_ENTRY_RESET = '{
        state: MS_STOPPED,
        speed: 16'd0,
        current: 16'd0,
        frames: 32'd0
    };

    typedef struct packed {
        kind_t kind;
        logic is_motor;
        logic [2:0] idx;
        logic set_state;
        motor_state_t new_state;
        logic set_telem;
        logic [15:0] speed;
        logic [15:0] current;
        logic set_fresh;
        logic set_temp;
        logic [14:0] cabin;
        logic [14:0] wall;
    } decode_t;

    function automatic logic [14:0] bcd_to_hundredths(input logic [15:0] w);
        logic [14:0] d3;
        logic [14:0] d2;
        logic [14:0] d1;
        logic [14:0] d0;
        d3 = 15'(w[15:12]) * 15'd1000;
        d2 = 15'(w[11:8]) * 15'd100;
        d1 = 15'(w[7:4]) * 15'd10;
        d0 = 15'(w[3:0]);
        return d3 + d2 + d1 + d0;
    endfunction

endpackage

[hw/rtl/motor_reply_frame_decoder.sv]
// A taken frame is decoded into the decode stage register; its result then goes to the
// output register. Throughput: one frame per cycle; a stalled result holds the frame
// behind it and stalls the input. The motor table memory is read when a frame is taken
// and written back when it leaves the decode stage, with forwarding of the last write.
// Reset: reply_base_id 0x581, temp_module_id 0x589, temperatures and fresh bits
// zero; per-entry valid bits make every motor read as stopped with zero values.
module motor_reply_frame_decoder
    import mrfd_pkg::*;
#(
    parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [10:0]        cfg_data,
    input  logic               frame_valid,
    output logic               frame_stall,
    input  logic [10:0]        frame_id,
    input  logic [3:0]         frame_len,
    input  logic [7:0]         byte0,
    input  logic [7:0]         byte1,
    input  logic [7:0]         byte2,
    input  logic [7:0]         byte3,
    input  logic [7:0]         byte4,
    input  logic [7:0]         byte5,
    input  logic [7:0]         byte6,
    input  logic [7:0]         byte7,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [2:0]         result_kind,
    output logic [2:0]         motor_index,
    output logic [1:0]         motor_state,
    output logic signed [15:0] motor_speed,
    output logic signed [15:0] motor_current,
    output logic [31:0]        motor_frames,
    output logic [14:0]        cabin_temperature,
    output logic [14:0]        wall_temperature,
    output logic [7:0]         fresh_mask
);

    localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

    logic [10:0]  reply_base_id_reg;
    logic [10:0]  temp_module_id_reg;
    decode_t      dec;
    logic         frame_accept;
    logic         s1_advance;
    logic         s1_valid_reg;
    logic         s1_valid_next;
    decode_t      s1_dec_reg;
    motor_entry_t entry_cur;
    motor_entry_t entry_upd;
    logic         mem_wr_en;
    logic [7:0]   fresh_reg;
    logic [7:0]   fresh_next;
    logic [14:0]  cabin_reg;
    logic [14:0]  cabin_next;
    logic [14:0]  wall_reg;
    logic [14:0]  wall_next;
    logic         result_valid_reg;
    logic         result_valid_next;
    kind_t        kind_reg;
    logic [2:0]   index_reg;
    logic [1:0]   state_reg;
    logic [15:0]  speed_reg;
    logic [15:0]  current_reg;
    logic [31:0]  frames_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reply_base_id_reg  <= REPLY_BASE_ID_RESET;
            temp_module_id_reg <= TEMP_MODULE_ID_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_REPLY_BASE_ID:  reply_base_id_reg  <= cfg_data;
                CFG_TEMP_MODULE_ID: temp_module_id_reg <= cfg_data;
                default:            reply_base_id_reg  <= reply_base_id_reg;
            endcase
        end
    end

    mrfd_decode #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_decode (
        .reply_base_id  (reply_base_id_reg),
        .temp_module_id (temp_module_id_reg),
        .frame_id       (frame_id),
        .frame_len      (frame_len),
        .byte0          (byte0),
        .byte3          (byte3),
        .byte4          (byte4),
        .byte5          (byte5),
        .byte6          (byte6),
        .byte7          (byte7),
        .dec            (dec)
    );

    assign s1_advance    = !result_valid_reg || !result_stall;
    assign frame_stall   = s1_valid_reg && !s1_advance;
    assign frame_accept  = frame_valid && !frame_stall;
    assign s1_valid_next = frame_accept || (s1_valid_reg && !s1_advance);
    assign mem_wr_en     = s1_valid_reg && s1_advance && s1_dec_reg.is_motor;

    mrfd_motor_mem #(
        .MOTOR_COUNT (MOTOR_COUNT),
        .IDX_W       (IDX_W)
    ) u_motor_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (frame_accept),
        .rd_addr (dec.idx[IDX_W-1:0]),
        .wr_en   (mem_wr_en),
        .wr_addr (s1_dec_reg.idx[IDX_W-1:0]),
        .wr_data (entry_upd),
        .rd_data (entry_cur)
    );

    mrfd_update u_update (
        .dec (s1_dec_reg),
        .cur (entry_cur),
        .upd (entry_upd)
    );

    always_comb
    begin
        fresh_next = fresh_reg;
        cabin_next = cabin_reg;
        wall_next  = wall_reg;
        if (s1_valid_reg && s1_dec_reg.set_fresh)
        begin
            fresh_next = fresh_reg | (8'd1 << s1_dec_reg.idx);
        end
        if (s1_valid_reg && s1_dec_reg.set_temp)
        begin
            cabin_next = s1_dec_reg.cabin;
            wall_next  = s1_dec_reg.wall;
        end
    end

    assign result_valid_next = (s1_valid_reg && s1_advance)
                             || (result_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            fresh_reg        <= 8'd0;
            cabin_reg        <= 15'd0;
            wall_reg         <= 15'd0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
            if (s1_valid_reg && s1_advance)
            begin
                fresh_reg <= fresh_next;
                cabin_reg <= cabin_next;
                wall_reg  <= wall_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_accept)
        begin
            s1_dec_reg <= dec;
        end
        if (s1_valid_reg && s1_advance)
        begin
            kind_reg <= s1_dec_reg.kind;
            if (s1_dec_reg.is_motor)
            begin
                index_reg   <= s1_dec_reg.idx;
                state_reg   <= entry_upd.state;
                speed_reg   <= entry_upd.speed;
                current_reg <= entry_upd.current;
                frames_reg  <= entry_upd.frames;
            end
            else
            begin
                index_reg   <= 3'd0;
                state_reg   <= 2'd0;
                speed_reg   <= 16'd0;
                current_reg <= 16'd0;
                frames_reg  <= 32'd0;
            end
        end
    end

    assign result_valid      = result_valid_reg;
    assign result_kind       = kind_reg;
    assign motor_index       = index_reg;
    assign motor_state       = state_reg;
    assign motor_speed       = speed_reg;
    assign motor_current     = current_reg;
    assign motor_frames      = frames_reg;
    assign cabin_temperature = cabin_reg;
    assign wall_temperature  = wall_reg;
    assign fresh_mask        = fresh_reg;

endmodule

[hw/rtl/mrfd_decode.sv]
module mrfd_decode
    import mrfd_pkg::*;
#(
    parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
)
(
    input  logic [10:0] reply_base_id,
    input  logic [10:0] temp_module_id,
    input  logic [10:0] frame_id,
    input  logic [3:0]  frame_len,
    input  logic [7:0]  byte0,
    input  logic [7:0]  byte3,
    input  logic [7:0]  byte4,
    input  logic [7:0]  byte5,
    input  logic [7:0]  byte6,
    input  logic [7:0]  byte7,
    output decode_t     dec
);

    logic [11:0] id_diff;
    logic        in_range;
    logic [15:0] raw_speed;

    assign id_diff   = {1'b0, frame_id} - {1'b0, reply_base_id};
    assign in_range  = !id_diff[11] && (id_diff[10:0] < 11'(MOTOR_COUNT));
    assign raw_speed = {byte5, byte4};

    always_comb
    begin
        dec           = '0;
        dec.kind      = KIND_UNKNOWN_ID;
        dec.new_state = MS_STOPPED;
        dec.speed     = raw_speed;
        dec.current   = {byte7, byte6};
        dec.cabin     = bcd_to_hundredths({byte5, byte4});
        dec.wall      = bcd_to_hundredths({byte7, byte6});
        if (frame_len != FRAME_LEN_VALID)
        begin
            dec.kind = KIND_BAD_LENGTH;
        end
        else if (frame_id == temp_module_id)
        begin
            dec.kind     = KIND_TEMPERATURE;
            dec.set_temp = 1'b1;
        end
        else if (in_range)
        begin
            dec.kind     = KIND_NO_CHANGE;
            dec.is_motor = 1'b1;
            dec.idx      = id_diff[2:0];
            if (byte0 == PREAMBLE_STATUS)
            begin
                dec.kind      = KIND_STATUS;
                dec.set_state = 1'b1;
                case (byte4)
                    STATUS_CODE_FAULT:   dec.new_state = MS_FAULT;
                    STATUS_CODE_STOPPED: dec.new_state = MS_STOPPED;
                    STATUS_CODE_STARTED: dec.new_state = MS_STARTED;
                    STATUS_CODE_ENABLED: dec.new_state = MS_ENABLED;
                    default:
                    begin
                        dec.kind      = KIND_NO_CHANGE;
                        dec.set_state = 1'b0;
                    end
                endcase
            end
            else if (byte0 == PREAMBLE_INFO)
            begin
                case (byte3)
                    INFO_FRESH_ONLY:
                    begin
                        dec.kind      = KIND_TELEMETRY;
                        dec.set_fresh = 1'b1;
                    end
                    INFO_FORWARD:
                    begin
                        dec.kind      = KIND_TELEMETRY;
                        dec.set_fresh = 1'b1;
                        dec.set_telem = 1'b1;
                    end
                    INFO_REVERSE:
                    begin
                        dec.kind      = KIND_TELEMETRY;
                        dec.set_fresh = 1'b1;
                        dec.set_telem = 1'b1;
                        dec.speed     = ~raw_speed + 16'd1;
                    end
                    default:
                    begin
                        dec.kind = KIND_NO_CHANGE;
                    end
                endcase
            end
        end
    end

endmodule

[hw/rtl/mrfd_motor_mem.sv]
module mrfd_motor_mem
    import mrfd_pkg::*;
#(
    parameter int MOTOR_COUNT = MOTOR_COUNT_DEF,
    parameter int IDX_W = 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  motor_entry_t     wr_data,
    output motor_entry_t     rd_data
);

    motor_entry_t mem [MOTOR_COUNT];

    logic [MOTOR_COUNT-1:0] valid_reg;
    logic [MOTOR_COUNT-1:0] valid_next;
    logic                   rd_valid_reg;
    logic [IDX_W-1:0]       rd_addr_reg;
    motor_entry_t           rd_data_reg;
    logic                   fwd_valid_reg;
    logic [IDX_W-1:0]       fwd_addr_reg;
    motor_entry_t           fwd_data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        if (wr_en)
        begin
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
            if (wr_en)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    // A write at the same edge as the read leaves the old entry in the read
    // register, so the last written entry is taken from the forward register.
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == rd_addr_reg))
        begin
            rd_data = fwd_data_reg;
        end
        else if (rd_valid_reg)
        begin
            rd_data = rd_data_reg;
        end
        else
        begin
            rd_data = MOTOR_ENTRY_RESET;
        end
    end

endmodule

[hw/rtl/mrfd_update.sv]
module mrfd_update
    import mrfd_pkg::*;
(
    input  decode_t      dec,
    input  motor_entry_t cur,
    output motor_entry_t upd
);

    always_comb
    begin
        upd        = cur;
        upd.frames = cur.frames + 32'd1;
        if (dec.set_state)
        begin
            upd.state = dec.new_state;
        end
        if (dec.set_telem)
        begin
            upd.speed   = dec.speed;
            upd.current = dec.current;
        end
    end

endmodule
